### hw/rtl/rrfp_pkg.sv
`default_nettype none

package rrfp_pkg;

  // EPC field clamp for inventory notices
  localparam int unsigned EPC_MAX = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTICE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CMD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_CMD = 3'd4;

  localparam logic [7:0] HEADER_RESET    = 8'hBB;
  localparam logic [7:0] END_RESET       = 8'h7E;
  localparam logic [7:0] NOTICE_RESET    = 8'h02;
  localparam logic [7:0] INV_CMD_RESET   = 8'h22;
  localparam logic [7:0] ERROR_CMD_RESET = 8'hFF;

  // smallest parameter list that carries a tag layout
  localparam logic [15:0] NOTICE_MIN_LEN = 16'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ROLE_PLAIN    = 3'd0;
  localparam logic [2:0] ROLE_RSSI     = 3'd1;
  localparam logic [2:0] ROLE_PC       = 3'd2;
  localparam logic [2:0] ROLE_EPC      = 3'd3;
  localparam logic [2:0] ROLE_CRC      = 3'd4;
  localparam logic [2:0] ROLE_EPC_OVER = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_STRAY     = 3'd1;
  localparam logic [2:0] ST_BAD_FRAME = 3'd2;
  localparam logic [2:0] ST_CHECKSUM  = 3'd3;
  localparam logic [2:0] ST_MOD_ERROR = 3'd4;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] end_value;
    logic [7:0] notice_type_value;
    logic [7:0] inventory_command_value;
    logic [7:0] error_command_value;
  } rrfp_cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_value;
    logic [7:0]  byte_index;
    logic [2:0]  tag_role;
    logic [2:0]  frame_status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_command;
    logic [15:0] param_length;
    logic [7:0]  module_error_code;
    logic        is_tag_notice;
    logic [5:0]  epc_length;
  } rrfp_result_t;

endpackage

`default_nettype wire

### hw/rtl/rrfp_cfg_regs.sv
`default_nettype none

module rrfp_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rrfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rrfp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output rrfp_pkg::rrfp_cfg_t                    cfg_o
);
  import rrfp_pkg::*;

  rrfp_cfg_t cfg_q, cfg_d;

  // unknown indexes drop the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HEADER:    cfg_d.header_value            = cfg_wdata_i;
        REG_END:       cfg_d.end_value               = cfg_wdata_i;
        REG_NOTICE:    cfg_d.notice_type_value       = cfg_wdata_i;
        REG_INV_CMD:   cfg_d.inventory_command_value = cfg_wdata_i;
        REG_ERROR_CMD: cfg_d.error_command_value     = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value            <= HEADER_RESET;
      cfg_q.end_value               <= END_RESET;
      cfg_q.notice_type_value       <= NOTICE_RESET;
      cfg_q.inventory_command_value <= INV_CMD_RESET;
      cfg_q.error_command_value     <= ERROR_CMD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/rrfp_parser.sv
`default_nettype none

module rrfp_parser #(
  parameter int unsigned MAX_PARAMS = 256
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   acc_i,
  input  wire logic [7:0]             rx_byte_i,
  input  wire rrfp_pkg::rrfp_cfg_t    cfg_i,
  output logic                        res_valid_o,
  output rrfp_pkg::rrfp_result_t      res_o
);
  import rrfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1);
  localparam logic [16:0] MAX_LEN = 17'(MAX_PARAMS);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_LENHI = 3'd3;
  localparam logic [2:0] PH_LENLO = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_CKSUM = 3'd6;
  localparam logic [2:0] PH_END   = 3'd7;

  logic [2:0]       phase_q, phase_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       rsum_q, rsum_d;
  logic [7:0]       first_q, first_d;

  logic         notice;
  logic [15:0]  epc_raw;
  logic [5:0]   epc_len;
  logic [15:0]  cnt16;
  logic [15:0]  cnt_inc;
  logic [2:0]   role;
  logic [15:0]  len_lo;

  assign notice = (type_q == cfg_i.notice_type_value) &&
                  (cmd_q == cfg_i.inventory_command_value) &&
                  (len_q >= NOTICE_MIN_LEN);
  assign epc_raw = len_q - NOTICE_MIN_LEN;
  assign epc_len = (epc_raw > 16'(EPC_MAX)) ? 6'(EPC_MAX) : epc_raw[5:0];
  assign cnt16   = 16'(cnt_q);
  assign cnt_inc = cnt16 + 16'd1;
  assign len_lo  = {len_q[15:8], rx_byte_i};

  // role of the current parameter byte in a tag notice
  always_comb begin
    priority if (!notice) begin
      role = ROLE_PLAIN;
    end else if (cnt16 == 16'd0) begin
      role = ROLE_RSSI;
    end else if (cnt16 <= 16'd2) begin
      role = ROLE_PC;
    end else if ((17'(cnt16) + 17'd2) >= 17'(len_q)) begin
      role = ROLE_CRC;
    end else if ((cnt16 - 16'd3) < 16'(EPC_MAX)) begin
      role = ROLE_EPC;
    end else begin
      role = ROLE_EPC_OVER;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    rsum_d      = rsum_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == cfg_i.header_value) begin
          phase_d = PH_TYPE;
        end else begin
          res_valid_o        = 1'b1;
          res_o.item_kind    = KIND_STATUS;
          res_o.frame_status = ST_STRAY;
        end
      end
      PH_TYPE: begin
        type_d  = rx_byte_i;
        sum_d   = rx_byte_i;
        phase_d = PH_CMD;
      end
      PH_CMD: begin
        cmd_d   = rx_byte_i;
        sum_d   = sum_q + rx_byte_i;
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        len_d   = {rx_byte_i, 8'h00};
        sum_d   = sum_q + rx_byte_i;
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        len_d   = len_lo;
        sum_d   = sum_q + rx_byte_i;
        cnt_d   = '0;
        first_d = '0;
        if (17'(len_lo) > MAX_LEN) begin
          phase_d             = PH_HUNT;
          res_valid_o         = 1'b1;
          res_o.item_kind     = KIND_STATUS;
          res_o.frame_status  = ST_BAD_FRAME;
          res_o.frame_type    = type_q;
          res_o.frame_command = cmd_q;
          res_o.param_length  = len_lo;
        end else if (len_lo == 16'd0) begin
          phase_d = PH_CKSUM;
        end else begin
          phase_d = PH_PARAM;
        end
      end
      PH_PARAM: begin
        res_valid_o         = 1'b1;
        res_o.item_kind     = KIND_PAYLOAD;
        res_o.data_value    = rx_byte_i;
        res_o.byte_index    = cnt16[7:0];
        res_o.tag_role      = role;
        res_o.frame_type    = type_q;
        res_o.frame_command = cmd_q;
        res_o.param_length  = len_q;
        res_o.is_tag_notice = notice;
        res_o.epc_length    = notice ? epc_len : 6'd0;
        if (cnt_q == '0) begin
          first_d = rx_byte_i;
        end
        sum_d = sum_q + rx_byte_i;
        cnt_d = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= len_q) begin
          phase_d = PH_CKSUM;
        end
      end
      PH_CKSUM: begin
        rsum_d  = rx_byte_i;
        phase_d = PH_END;
      end
      PH_END: begin
        phase_d             = PH_HUNT;
        res_valid_o         = 1'b1;
        res_o.item_kind     = KIND_STATUS;
        res_o.frame_type    = type_q;
        res_o.frame_command = cmd_q;
        res_o.param_length  = len_q;
        priority if (rx_byte_i != cfg_i.end_value) begin
          res_o.frame_status = ST_BAD_FRAME;
        end else if (sum_q != rsum_q) begin
          res_o.frame_status = ST_CHECKSUM;
        end else if ((cmd_q == cfg_i.error_command_value) && (len_q != 16'd0)) begin
          res_o.frame_status      = ST_MOD_ERROR;
          res_o.module_error_code = first_q;
        end else begin
          res_o.frame_status  = ST_OK;
          res_o.is_tag_notice = notice;
          res_o.epc_length    = notice ? epc_len : 6'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      type_q  <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      rsum_q  <= '0;
      first_q <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      rsum_q  <= rsum_d;
      first_q <= first_d;
    end
  end

`ifndef ASSERT_OFF
  a_param_gives_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && (phase_q == PH_PARAM)) |-> (res_valid_o && (res_o.item_kind == KIND_PAYLOAD)))
    else $error("parameter byte produced no payload item");
  a_count_below_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PARAM) |-> (16'(cnt_q) < len_q))
    else $error("parameter count reached the length while still in parameters");
  a_status_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && res_valid_o && (res_o.item_kind == KIND_STATUS)) |=> (phase_q == PH_HUNT))
    else $error("status item not followed by header hunt");
`endif

endmodule

`default_nettype wire

### hw/rtl/rrfp_out_buf.sv
`default_nettype none

module rrfp_out_buf (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    res_valid_i,
  input  wire rrfp_pkg::rrfp_result_t  res_i,
  output logic                         full_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output rrfp_pkg::rrfp_result_t       out_o
);
  import rrfp_pkg::*;

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  rrfp_result_t out_q, out_d;
  rrfp_result_t skid_q, skid_d;
  logic         take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = res_valid_i;
        skid_d       = res_i;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      // hold the output, park the new item
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output is empty");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && res_valid_i) |-> take)
    else $error("item arrived with both stages full");
`endif

endmodule

`default_nettype wire

### hw/rtl/reader_reply_frame_parser.sv
`default_nettype none

// Reply-frame deframer for a serial reader link.
// Input channel: one received byte per item on rx_byte_i, in_valid_i/in_stall_o.
// Output channel: result items on the *_o field ports, out_valid_o/out_stall_i.
// An item moves at a clock edge where valid is high and stall is low.
// Each accepted byte updates the registered frame state; a byte that yields
// a result (parameter byte, stray byte, end of frame, over-long length) has it
// registered into the output register, or into the skid stage while the
// output is held. Header, type, command, length and checksum bytes yield
// nothing. Throughput: one byte per cycle while in_stall_o is low.
// Stalls: a two-entry output buffer (output register plus skid) lets a byte
// be taken while a result waits; in_stall_o rises once the skid stage holds
// an item and falls once the output item is taken and the skid item moves up.
// Configuration: write cfg_wdata_i to register cfg_index_i with cfg_we_i,
// only while the block is idle; unknown indexes are dropped.
// Reset: the parser hunts for the header, registers take their defaults,
// and the output is empty.
module reader_reply_frame_parser #(
  parameter int unsigned MAX_PARAMS = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rrfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rrfp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      rx_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 item_kind_o,
  output logic [7:0]                           data_value_o,
  output logic [7:0]                           byte_index_o,
  output logic [2:0]                           tag_role_o,
  output logic [2:0]                           frame_status_o,
  output logic [7:0]                           frame_type_o,
  output logic [7:0]                           frame_command_o,
  output logic [15:0]                          param_length_o,
  output logic [7:0]                           module_error_code_o,
  output logic                                 is_tag_notice_o,
  output logic [5:0]                           epc_length_o
);
  import rrfp_pkg::*;

  rrfp_cfg_t    cfg;
  rrfp_result_t res;
  rrfp_result_t out_item;
  logic         res_valid;
  logic         acc;
  logic         buf_full;

  // advance the parser only on an accepted byte
  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = buf_full;

  rrfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rrfp_parser #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // results only count when the byte behind them was taken
  rrfp_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid && acc),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_item)
  );

  assign item_kind_o         = out_item.item_kind;
  assign data_value_o        = out_item.data_value;
  assign byte_index_o        = out_item.byte_index;
  assign tag_role_o          = out_item.tag_role;
  assign frame_status_o      = out_item.frame_status;
  assign frame_type_o        = out_item.frame_type;
  assign frame_command_o     = out_item.frame_command;
  assign param_length_o      = out_item.param_length;
  assign module_error_code_o = out_item.module_error_code;
  assign is_tag_notice_o     = out_item.is_tag_notice;
  assign epc_length_o        = out_item.epc_length;

endmodule

`default_nettype wire

### tb/reader_reply_frame_parser_tb.sv
module reader_reply_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfp_pkg::*;

  // Longest parameter list the parser accepts; the instance gets the same value
  localparam int unsigned PARAM_LIMIT = 256;
  // Cycles to let pass after the last result before touching registers
  localparam int unsigned SETTLE_CYCLES = 4;
  // Receiver hold-off long enough to fill the output buffer and stall input
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned RUN_LIMIT = 200000;

  typedef enum logic [2:0] {
    HUNT, GET_TYPE, GET_CMD, GET_LEN_HI, GET_LEN_LO, GET_PARAM, GET_SUM, GET_END
  } parse_phase_e;

  // Frame parser prediction plus the queue of result items still to arrive
  class frame_reply_scoreboard;
    rrfp_cfg_t    regs;
    parse_phase_e phase;
    logic [7:0]   cur_type, cur_cmd, sum_acc, sum_rx, first_byte;
    logic [15:0]  cur_len, param_idx;
    rrfp_result_t awaited_items[$];
    int           errors;

    function new();
      regs = '{HEADER_RESET, END_RESET, NOTICE_RESET, INV_CMD_RESET, ERROR_CMD_RESET};
      phase = HUNT;
      cur_type = '0;
      cur_cmd = '0;
      cur_len = '0;
      param_idx = '0;
      sum_acc = '0;
      sum_rx = '0;
      first_byte = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      case (idx)
        REG_HEADER:    regs.header_value = value;
        REG_END:       regs.end_value = value;
        REG_NOTICE:    regs.notice_type_value = value;
        REG_INV_CMD:   regs.inventory_command_value = value;
        REG_ERROR_CMD: regs.error_command_value = value;
        default: ;
      endcase
    endfunction

    function bit tag_layout();
      return cur_type == regs.notice_type_value && cur_cmd == regs.inventory_command_value &&
             cur_len >= NOTICE_MIN_LEN;
    endfunction

    function logic [5:0] epc_count();
      int unsigned n;
      n = int'(cur_len) - int'(NOTICE_MIN_LEN);
      if (n > EPC_MAX) n = EPC_MAX;
      return n[5:0];
    endfunction

    function rrfp_result_t frame_fields(bit notice_flag);
      rrfp_result_t r;
      r = '0;
      r.frame_type = cur_type;
      r.frame_command = cur_cmd;
      r.param_length = cur_len;
      r.is_tag_notice = notice_flag;
      r.epc_length = notice_flag ? epc_count() : 6'd0;
      return r;
    endfunction

    function void push_status(logic [2:0] st, bit with_frame);
      rrfp_result_t r;
      r = with_frame ? frame_fields(st == ST_OK && tag_layout()) : '0;
      r.item_kind = KIND_STATUS;
      r.frame_status = st;
      if (st == ST_MOD_ERROR) r.module_error_code = first_byte;
      awaited_items.push_back(r);
    endfunction

    function logic [2:0] role_of(int unsigned idx);
      if (!tag_layout()) return ROLE_PLAIN;
      if (idx == 0) return ROLE_RSSI;
      if (idx <= 2) return ROLE_PC;
      if (idx + 2 >= cur_len) return ROLE_CRC;
      return (idx - 3 < EPC_MAX) ? ROLE_EPC : ROLE_EPC_OVER;
    endfunction

    // Advance the parser by one accepted byte and queue what it yields
    function void parse_byte(logic [7:0] b);
      rrfp_result_t r;
      case (phase)
        HUNT: begin
          if (b == regs.header_value) phase = GET_TYPE;
          else push_status(ST_STRAY, 1'b0);
        end
        GET_TYPE: begin
          cur_type = b;
          sum_acc = b;
          phase = GET_CMD;
        end
        GET_CMD: begin
          cur_cmd = b;
          sum_acc += b;
          phase = GET_LEN_HI;
        end
        GET_LEN_HI: begin
          cur_len = {b, 8'h00};
          sum_acc += b;
          phase = GET_LEN_LO;
        end
        GET_LEN_LO: begin
          cur_len[7:0] = b;
          sum_acc += b;
          param_idx = '0;
          first_byte = '0;
          if (cur_len > PARAM_LIMIT) begin
            phase = HUNT;
            push_status(ST_BAD_FRAME, 1'b1);
          end else begin
            phase = (cur_len == 0) ? GET_SUM : GET_PARAM;
          end
        end
        GET_PARAM: begin
          r = frame_fields(tag_layout());
          r.item_kind = KIND_PAYLOAD;
          r.data_value = b;
          r.byte_index = param_idx[7:0];
          r.tag_role = role_of(param_idx);
          awaited_items.push_back(r);
          if (param_idx == 0) first_byte = b;
          sum_acc += b;
          param_idx++;
          if (param_idx >= cur_len) phase = GET_SUM;
        end
        GET_SUM: begin
          sum_rx = b;
          phase = GET_END;
        end
        default: begin
          phase = HUNT;
          if (b != regs.end_value) push_status(ST_BAD_FRAME, 1'b1);
          else if (sum_acc != sum_rx) push_status(ST_CHECKSUM, 1'b1);
          else if (cur_cmd == regs.error_command_value && cur_len >= 1)
            push_status(ST_MOD_ERROR, 1'b1);
          else push_status(ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
      end
    endfunction

    function void check_item(rrfp_result_t seen);
      rrfp_result_t want;
      if (awaited_items.size() == 0) begin
        errors++;
        $display("%0t: item with nothing expected, expected none, got %h", $time, seen);
        return;
      end
      want = awaited_items.pop_front();
      compare_field("item_kind", want.item_kind, seen.item_kind);
      compare_field("data_value", want.data_value, seen.data_value);
      compare_field("byte_index", want.byte_index, seen.byte_index);
      compare_field("tag_role", want.tag_role, seen.tag_role);
      compare_field("frame_status", want.frame_status, seen.frame_status);
      compare_field("frame_type", want.frame_type, seen.frame_type);
      compare_field("frame_command", want.frame_command, seen.frame_command);
      compare_field("param_length", want.param_length, seen.param_length);
      compare_field("module_error_code", want.module_error_code, seen.module_error_code);
      compare_field("is_tag_notice", want.is_tag_notice, seen.is_tag_notice);
      compare_field("epc_length", want.epc_length, seen.epc_length);
    endfunction

    function int pending();
      return awaited_items.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  item_kind_o;
  logic [7:0]            data_value_o;
  logic [7:0]            byte_index_o;
  logic [2:0]            tag_role_o;
  logic [2:0]            frame_status_o;
  logic [7:0]            frame_type_o;
  logic [7:0]            frame_command_o;
  logic [15:0]           param_length_o;
  logic [7:0]            module_error_code_o;
  logic                  is_tag_notice_o;
  logic [5:0]            epc_length_o;

  frame_reply_scoreboard reply_board;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned hold_left;
  bit          hold_off_req;

  reader_reply_frame_parser #(
    .MAX_PARAMS(PARAM_LIMIT)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .item_kind_o        (item_kind_o),
    .data_value_o       (data_value_o),
    .byte_index_o       (byte_index_o),
    .tag_role_o         (tag_role_o),
    .frame_status_o     (frame_status_o),
    .frame_type_o       (frame_type_o),
    .frame_command_o    (frame_command_o),
    .param_length_o     (param_length_o),
    .module_error_code_o(module_error_code_o),
    .is_tag_notice_o    (is_tag_notice_o),
    .epc_length_o       (epc_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Guard against a hung handshake: give up well past the slowest good run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver side: stall at random, or hold off for a long stretch on request.
  // The hold-off is counted here so the sender carries on regardless.
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // Sample every result item that moves and check it against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      reply_board.check_item({item_kind_o, data_value_o, byte_index_o, tag_role_o,
                              frame_status_o, frame_type_o, frame_command_o,
                              param_length_o, module_error_code_o, is_tag_notice_o,
                              epc_length_o});
  end

  // Offer one byte, idling first at random; hold it until the parser takes it.
  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reply_board.parse_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Send one frame built from the current register values. A cut frame stops
  // after 'keep' parameter bytes, so later bytes get swallowed as parameters.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fcmd,
                            input logic [15:0] flen, input bit sum_ok, input bit end_ok,
                            input bit cut, input int unsigned keep);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(reply_board.regs.header_value);
    send_byte(ftype);
    send_byte(fcmd);
    send_byte(flen[15:8]);
    send_byte(flen[7:0]);
    sum = ftype + fcmd + flen[15:8] + flen[7:0];
    // an over-long length ends the frame right here
    if (flen > PARAM_LIMIT) return;
    for (int unsigned i = 0; i < flen; i++) begin
      if (cut && i >= keep) return;
      b = 8'($urandom_range(0, 255));
      send_byte(b);
      sum += b;
    end
    if (cut) return;
    send_byte(sum_ok ? sum : sum + 8'($urandom_range(1, 255)));
    send_byte(end_ok ? reply_board.regs.end_value
                     : reply_board.regs.end_value + 8'($urandom_range(1, 255)));
  endtask

  // Mostly well-formed frames with random content, biased towards tag notices,
  // error frames, short lists, lists past the EPC clamp and over-long lengths
  task automatic send_random_frame();
    logic [7:0]  ftype;
    logic [7:0]  fcmd;
    logic [15:0] flen;
    int unsigned pick;
    bit          cut;
    ftype = ($urandom_range(0, 99) < 60) ? reply_board.regs.notice_type_value
                                         : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) fcmd = reply_board.regs.inventory_command_value;
    else if (pick < 65) fcmd = reply_board.regs.error_command_value;
    else fcmd = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 1) flen = PARAM_LIMIT;
    else if (pick < 5) flen = PARAM_LIMIT + 1;
    else if (pick < 7) flen = 16'hFFFF;
    else if (pick < 12) flen = 16'($urandom_range(PARAM_LIMIT + 2, 16'hFFFF));
    else if (pick < 25) flen = 16'($urandom_range(NOTICE_MIN_LEN + EPC_MAX - 2,
                                                  NOTICE_MIN_LEN + EPC_MAX + 8));
    else flen = 16'($urandom_range(0, 12));
    cut = ($urandom_range(0, 99) < 8);
    send_frame(ftype, fcmd, flen, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85,
               cut, cut ? $urandom_range(0, flen) : flen);
  endtask

  // Either a burst of line noise or a frame
  task automatic send_traffic();
    int unsigned noise;
    if ($urandom_range(0, 99) < 15) begin
      noise = $urandom_range(1, 3);
      repeat (noise) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_random_frame();
    end
  endtask

  // Drop valid and wait until every expected item is out and the parser is quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (reply_board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    reply_board.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  // Write all five registers, then hit the unused indexes, which must be dropped
  task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] eom,
                                input logic [7:0] notice, input logic [7:0] inv_cmd,
                                input logic [7:0] err_cmd);
    program_reg(REG_HEADER, hdr);
    program_reg(REG_END, eom);
    program_reg(REG_NOTICE, notice);
    program_reg(REG_INV_CMD, inv_cmd);
    program_reg(REG_ERROR_CMD, err_cmd);
    for (int k = int'(REG_ERROR_CMD) + 1; k < (1 << CFG_IDX_W); k++)
      program_reg(CFG_IDX_W'(k), 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    int unsigned drained;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    in_idle_pct  = 20;
    out_idle_pct = 81;
    bytes_sent   = 0;
    cycle_count  = 0;
    hold_off_req = 1'b0;
    reply_board  = new();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset register values.
    // Stray byte while hunting.
    send_byte(8'h00);
    // Largest length: bad frame straight after the length bytes.
    send_frame(8'h00, 8'h00, 16'hFFFF, 1'b1, 1'b1, 1'b0, 0);
    // Zero length with a wrong end marker and a wrong checksum: end marker wins.
    send_frame(8'h01, 8'h10, 16'h0000, 1'b0, 1'b0, 1'b0, 0);
    // Zero length, checksum mismatch only.
    send_frame(8'h01, 8'h10, 16'h0000, 1'b0, 1'b1, 1'b0, 0);
    // Module error carrying its error code.
    send_frame(8'h01, reply_board.regs.error_command_value, 16'h0001, 1'b1, 1'b1, 1'b0, 1);

    // Random part: six phases, each with its own registers and idling
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: apply_settings(HEADER_RESET, END_RESET, NOTICE_RESET, INV_CMD_RESET,
                          ERROR_CMD_RESET);
        1: apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        2: apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        5: apply_settings(HEADER_RESET, END_RESET, NOTICE_RESET, INV_CMD_RESET,
                          ERROR_CMD_RESET);
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
      endcase
      // swap the idling sides after two phases, then stop idling altogether
      if (p < 2) begin
        in_idle_pct  = 20;
        out_idle_pct = 81;
      end else if (p < 4) begin
        in_idle_pct  = 81;
        out_idle_pct = 20;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      // long receiver hold-off while the sender keeps pushing
      if (p == 3 || p == 4) hold_off_req = 1'b1;
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) send_traffic();
    end

    // Drain: wait for the last results, bounded, then let the pipeline settle
    in_valid_i <= 1'b0;
    drained = 0;
    while (reply_board.pending() != 0 && drained < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drained++;
    end
    repeat (SETTLE_CYCLES * 2) @(negedge clk_i);
    if (reply_board.pending() != 0) begin
      reply_board.errors++;
      $display("%0t: expected %0d more items, got none", $time, reply_board.pending());
    end

    if (reply_board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
